FILE: src/nearest_neighbor_scaled_blit_walker_defines.svh
// ----------------------------------------------------------------------------
// Blit walker assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SCALED_BLIT_WALKER_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALED_BLIT_WALKER_DEFINES_SVH

`ifndef SYNTHESIS
// property holds in the same cycle
`define NNSB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nnsb assertion failed");
// antecedent implies consequent in the following cycle
`define NNSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnsb assertion failed");
`else
`define NNSB_ASSERT(lbl, clk, rst_n, prop)
`define NNSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/nnsb_pkg.sv
// ----------------------------------------------------------------------------
// nnsb_pkg
// Shared widths, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package nnsb_pkg;

    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 13;
    localparam int PROD_W   = COORD_W + SIZE_W;
    localparam int STEP_W   = $clog2(PROD_W);
    localparam int IDX_W    = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * COORD_W - 2 * SIZE_W;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_CORNER_A_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_CORNER_A_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CORNER_B_X    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CORNER_B_Y    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd5;
    localparam logic [IDX_W-1:0] REG_DEST_WIDTH    = 3'd6;
    localparam logic [IDX_W-1:0] REG_DEST_HEIGHT   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;      // input item accepted this cycle
        logic prep;      // form products, pixel coordinates, load dividers
        logic div_step;  // one quotient bit
        logic load_out;  // load output register
    } cmd_t;

    typedef struct packed {
        logic idle_item; // current input yields the idle/empty result
        logic out_free;  // output register can take a new item
    } status_t;

endpackage

FILE: src/nearest_neighbor_scaled_blit_walker.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_blit_walker
// Sequence: a pixel item is accepted, then setup (ST_PREP), 25 divide steps
//   (ST_DIV) and the output load (ST_OUT); an idle item goes straight to the load.
// A new item is accepted only after the output load of the last one, which
//   waits for a free output register; the bit-serial x and y dividers run in parallel.
// Reset: asynchronous active-low; registers go to corners 0, sizes 1, no walk.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaled_blit_walker
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [nnsb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [0] restart
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [11:0] src_x, [23:12] src_y, [36:24] dst_x, [49:37] dst_y
    output logic [nnsb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tuser,  // [0] write_enable
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [nnsb_pkg::IDX_W-1:0]            cfg_index,
    input  logic [nnsb_pkg::SIZE_W-1:0]           cfg_data
);

    nnsb_pkg::cmd_t               cmd;
    nnsb_pkg::status_t            stat;
    logic [nnsb_pkg::COORD_W-1:0] src_x, src_y;
    logic [nnsb_pkg::SIZE_W-1:0]  dst_x, dst_y;

    assign cfg_ready = 1'b1;

    nnsb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nnsb_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .restart      (s_axis_tdata[0]),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .src_x        (src_x),
        .src_y        (src_y),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .write_enable (m_axis_tuser),
        .last         (m_axis_tlast)
    );

    assign m_axis_tdata = {{nnsb_pkg::OUT_PAD_W{1'b0}}, dst_y, dst_x, src_y, src_x};

endmodule

FILE: src/nnsb_div.sv
// ----------------------------------------------------------------------------
// nnsb_div
// Restoring divider, one quotient bit per step; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module nnsb_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic                             step,
    input  logic [nnsb_pkg::PROD_W-1:0]      dividend,
    input  logic [nnsb_pkg::COORD_W-1:0]     divisor,
    output logic [nnsb_pkg::COORD_W-1:0]     quotient
);

    logic [nnsb_pkg::PROD_W-1:0]  dvd_reg, dvd_next;
    logic [nnsb_pkg::COORD_W-1:0] dsr_reg, dsr_next;
    logic [nnsb_pkg::COORD_W-1:0] rem_reg, rem_next;
    logic [nnsb_pkg::COORD_W-1:0] quo_reg, quo_next;
    logic [nnsb_pkg::COORD_W:0]   trial;
    logic [nnsb_pkg::COORD_W:0]   diff;
    logic                         fits;

    // remainder stays below divisor, so it fits the divisor width
    assign trial = {rem_reg, dvd_reg[nnsb_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            quo_next = '0;
        end
        else if (step)
        begin
            dvd_next = {dvd_reg[nnsb_pkg::PROD_W-2:0], 1'b0};
            rem_next = fits ? diff[nnsb_pkg::COORD_W-1:0] : trial[nnsb_pkg::COORD_W-1:0];
            quo_next = {quo_reg[nnsb_pkg::COORD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;

endmodule

FILE: src/nnsb_dp.sv
// ----------------------------------------------------------------------------
// nnsb_dp
// Datapath: configuration registers, walk counters, product and divide
// units, output register.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_scaled_blit_walker_defines.svh"

module nnsb_dp
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nnsb_pkg::cmd_t                      cmd,
    output nnsb_pkg::status_t                   stat,
    input  logic                                restart,
    input  logic                                cfg_write,
    input  logic [nnsb_pkg::IDX_W-1:0]          cfg_index,
    input  logic [nnsb_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [nnsb_pkg::COORD_W-1:0]        src_x,
    output logic [nnsb_pkg::COORD_W-1:0]        src_y,
    output logic [nnsb_pkg::SIZE_W-1:0]         dst_x,
    output logic [nnsb_pkg::SIZE_W-1:0]         dst_y,
    output logic                                write_enable,
    output logic                                last
);

    localparam int SIZE_MAX = (1 << nnsb_pkg::SIZE_W) - 1;
    localparam int SIZE_CAP = (MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM;
    localparam logic [nnsb_pkg::SIZE_W-1:0] CAP = nnsb_pkg::SIZE_W'(SIZE_CAP);

    // configuration
    logic [nnsb_pkg::COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [nnsb_pkg::SIZE_W-1:0]  sw_reg, sh_reg, dw_reg, dh_reg;

    // walk state
    logic [nnsb_pkg::COORD_W-1:0] col_reg, col_next;
    logic [nnsb_pkg::COORD_W-1:0] row_reg, row_next;
    logic                         done_reg, done_next;
    logic                         idle_reg, idle_next;

    // per-pixel results
    logic [nnsb_pkg::SIZE_W-1:0]  dx_reg, dy_reg;
    logic                         we_reg, fin_reg;
    logic                         ov_reg, ov_next;
    logic [nnsb_pkg::COORD_W-1:0] osx_reg, osy_reg;
    logic [nnsb_pkg::SIZE_W-1:0]  odx_reg, ody_reg;
    logic                         owe_reg, olast_reg;

    logic [nnsb_pkg::COORD_W-1:0] w, h, x0, y0, col_inc;
    logic [nnsb_pkg::SIZE_W-1:0]  sx, sy, dx, dy;
    logic [nnsb_pkg::PROD_W-1:0]  prod_x, prod_y;
    logic [nnsb_pkg::COORD_W-1:0] qx, qy;
    logic                         fin, idle_case;

    function automatic logic [nnsb_pkg::SIZE_W-1:0] size_less_one(
        input logic [nnsb_pkg::SIZE_W-1:0] s,
        input logic [nnsb_pkg::SIZE_W-1:0] cap
    );
        logic [nnsb_pkg::SIZE_W-1:0] c;
        c = (s == '0) ? nnsb_pkg::SIZE_W'(1) : ((s > cap) ? cap : s);
        return c - nnsb_pkg::SIZE_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
            sw_reg <= nnsb_pkg::SIZE_W'(1);
            sh_reg <= nnsb_pkg::SIZE_W'(1);
            dw_reg <= nnsb_pkg::SIZE_W'(1);
            dh_reg <= nnsb_pkg::SIZE_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                nnsb_pkg::REG_CORNER_A_X:    ax_reg <= cfg_data[nnsb_pkg::COORD_W-1:0];
                nnsb_pkg::REG_CORNER_A_Y:    ay_reg <= cfg_data[nnsb_pkg::COORD_W-1:0];
                nnsb_pkg::REG_CORNER_B_X:    bx_reg <= cfg_data[nnsb_pkg::COORD_W-1:0];
                nnsb_pkg::REG_CORNER_B_Y:    by_reg <= cfg_data[nnsb_pkg::COORD_W-1:0];
                nnsb_pkg::REG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                nnsb_pkg::REG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                nnsb_pkg::REG_DEST_WIDTH:    dw_reg <= cfg_data;
                nnsb_pkg::REG_DEST_HEIGHT:   dh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w  = (ax_reg > bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
    assign h  = (ay_reg > by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
    assign x0 = (ax_reg < bx_reg) ? ax_reg : bx_reg;
    assign y0 = (ay_reg < by_reg) ? ay_reg : by_reg;

    assign idle_case = (!restart && done_reg) || (w == '0) || (h == '0);
    assign col_inc   = col_reg + nnsb_pkg::COORD_W'(1);

    assign sx     = size_less_one(sw_reg, CAP);
    assign sy     = size_less_one(sh_reg, CAP);
    assign prod_x = nnsb_pkg::PROD_W'(col_reg) * nnsb_pkg::PROD_W'(sx);
    assign prod_y = nnsb_pkg::PROD_W'(row_reg) * nnsb_pkg::PROD_W'(sy);
    assign dx     = {1'b0, x0} + {1'b0, col_reg};
    assign dy     = {1'b0, y0} + {1'b0, row_reg};
    assign fin    = (col_reg == w - nnsb_pkg::COORD_W'(1)) &&
                    (row_reg >= h - nnsb_pkg::COORD_W'(1));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        idle_next = idle_reg;
        if (cmd.take)
        begin
            idle_next = idle_case;
            if (idle_case)
            begin
                done_next = 1'b1;
            end
            else if (restart)
            begin
                col_next  = '0;
                row_next  = '0;
                done_next = 1'b0;
            end
            else if (col_inc >= w)
            begin
                col_next = '0;
                row_next = row_reg + nnsb_pkg::COORD_W'(1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
        else if (cmd.prep && fin)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            done_reg <= 1'b1;
            idle_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
            idle_reg <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            dx_reg  <= dx;
            dy_reg  <= dy;
            we_reg  <= (dx < dw_reg) && (dy < dh_reg);
            fin_reg <= fin;
        end
    end

    nnsb_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.prep),
        .step     (cmd.div_step),
        .dividend (prod_x),
        .divisor  (w),
        .quotient (qx)
    );

    nnsb_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.prep),
        .step     (cmd.div_step),
        .dividend (prod_y),
        .divisor  (h),
        .quotient (qy)
    );

    // output register
    assign ov_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (idle_reg)
            begin
                osx_reg   <= '0;
                osy_reg   <= '0;
                odx_reg   <= '0;
                ody_reg   <= '0;
                owe_reg   <= 1'b0;
                olast_reg <= 1'b1;
            end
            else
            begin
                osx_reg   <= qx;
                osy_reg   <= qy;
                odx_reg   <= dx_reg;
                ody_reg   <= dy_reg;
                owe_reg   <= we_reg;
                olast_reg <= fin_reg;
            end
        end
    end

    assign stat.idle_item = idle_case;
    assign stat.out_free  = !ov_reg || out_ready;

    assign out_valid    = ov_reg;
    assign src_x        = osx_reg;
    assign src_y        = osy_reg;
    assign dst_x        = odx_reg;
    assign dst_y        = ody_reg;
    assign write_enable = owe_reg;
    assign last         = olast_reg;

    `NNSB_ASSERT(a_load_when_free, clk, rst_n, !cmd.load_out || stat.out_free)
    `NNSB_ASSERT_NEXT(a_idle_item_last, clk, rst_n, cmd.load_out && idle_reg,
        out_valid && last && !write_enable)
    `NNSB_ASSERT_NEXT(a_fin_ends_walk, clk, rst_n, cmd.prep && fin, done_reg)

endmodule

FILE: src/nnsb_ctrl.sv
// ----------------------------------------------------------------------------
// nnsb_ctrl
// Controller: input handshake, sequencing of product, divide and output load.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_scaled_blit_walker_defines.svh"

module nnsb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  nnsb_pkg::status_t  stat,
    output nnsb_pkg::cmd_t     cmd
);

    localparam logic [nnsb_pkg::STEP_W-1:0] LAST_STEP = nnsb_pkg::STEP_W'(nnsb_pkg::PROD_W - 1);

    nnsb_pkg::state_t             state_reg, state_next;
    logic [nnsb_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         take;

    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nnsb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.idle_item ? nnsb_pkg::ST_OUT : nnsb_pkg::ST_PREP;
                end
            end
            nnsb_pkg::ST_PREP: state_next = nnsb_pkg::ST_DIV;
            nnsb_pkg::ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = nnsb_pkg::ST_OUT;
                end
            end
            nnsb_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = nnsb_pkg::ST_IDLE;
                end
            end
            default: state_next = nnsb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        step_next    = step_reg;
        unique case (state_reg)
            nnsb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = take;
            end
            nnsb_pkg::ST_PREP:
            begin
                cmd.prep  = 1'b1;
                step_next = '0;
            end
            nnsb_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + nnsb_pkg::STEP_W'(1);
            end
            nnsb_pkg::ST_OUT:
            begin
                cmd.load_out = stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nnsb_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `NNSB_ASSERT_NEXT(a_prep_to_div, clk, rst_n, state_reg == nnsb_pkg::ST_PREP,
        state_reg == nnsb_pkg::ST_DIV && step_reg == '0)
    `NNSB_ASSERT_NEXT(a_div_runs, clk, rst_n,
        state_reg == nnsb_pkg::ST_DIV && step_reg != LAST_STEP,
        state_reg == nnsb_pkg::ST_DIV && step_reg == $past(step_reg) + nnsb_pkg::STEP_W'(1))
    `NNSB_ASSERT(a_take_only_idle, clk, rst_n,
        !(cmd.take || in_ready) || state_reg == nnsb_pkg::ST_IDLE)

endmodule
